// ===== src/rsas_pkg.sv =====
`default_nettype none

package rsas_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int IDX_W  = ADDR_W + 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int IN_W   = 72;
  localparam int OUT_W  = 8;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_P_ITER,
    S_P_M,
    S_P_N,
    S_P_P,
    S_P_L,
    S_C_PIV,
    S_C_PV,
    S_C_Z,
    S_B_ITER,
    S_B_CMP,
    S_RES
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_START,
    DP_MID,
    DP_CAP_VM,
    DP_PIV_MID,
    DP_PIV_MIDM1,
    DP_PIV_LO,
    DP_HI_MIDM1,
    DP_LO_MIDP1,
    DP_BIS_FULL,
    DP_BIS_LOW,
    DP_BIS_HIGH,
    DP_RES_HIT_PIV,
    DP_RES_HIT_MID,
    DP_RES_MISS
  } dp_op_t;

  typedef enum logic [2:0] {
    RD_MIDW,
    RD_MIDP1,
    RD_MIDM1,
    RD_LO,
    RD_ZERO,
    RD_PIV
  } rd_sel_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic lo_gt_hi;
    logic lo_eq_hi;
    logic mid_lt_hi;
    logic mid_gt_lo;
    logic vm_gt_rd;
    logic vm_lt_rd;
    logic rd_ge_vm;
    logic key_eq_rd;
    logic key_gt_rd;
    logic rd_le_key;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== src/rsas_datapath.sv =====
`default_nettype none

module rsas_datapath
  import rsas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire logic [IN_W-1:0]   in_data,
  input  wire cmd_t              cmd,
  output status_t                st,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       out_data
);

  logic [DATA_W-1:0]        mem [DEPTH];
  logic [CNT_W-1:0]         elem_count;
  logic [CNT_W-1:0]         n;
  logic signed [IDX_W-1:0]  lo;
  logic signed [IDX_W-1:0]  hi;
  logic [ADDR_W-1:0]        mid;
  logic [ADDR_W-1:0]        piv;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] vm;
  logic signed [DATA_W-1:0] rdata;
  logic                     res_found;
  logic [POS_W-1:0]         res_pos;
  logic                     out_found;
  logic [POS_W-1:0]         out_pos;

  logic [ADDR_W-1:0]        in_index;
  logic [DATA_W-1:0]        in_value;
  logic [DATA_W-1:0]        in_key;
  logic [CNT_W-1:0]         n_clamp;
  logic [IDX_W-1:0]         lo_hi_sum;
  logic [ADDR_W-1:0]        mid_w;
  logic [ADDR_W-1:0]        rd_addr;
  logic signed [IDX_W-1:0]  mid_s;
  logic signed [IDX_W-1:0]  piv_s;
  logic signed [IDX_W-1:0]  n_s;

  assign in_index  = in_data[ADDR_W-1:0];
  assign in_value  = in_data[ADDR_W+DATA_W-1:ADDR_W];
  assign in_key    = in_data[ADDR_W+2*DATA_W-1:ADDR_W+DATA_W];
  assign n_clamp   = (elem_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : elem_count;
  assign lo_hi_sum = lo + hi;
  assign mid_w     = lo_hi_sum[ADDR_W:1];
  assign mid_s     = $signed({2'b00, mid});
  assign piv_s     = $signed({2'b00, piv});
  assign n_s       = $signed({1'b0, n});

  always_comb begin
    case (cmd.rd)
      RD_MIDW:  rd_addr = mid_w;
      RD_MIDP1: rd_addr = mid + ADDR_W'(1);
      RD_MIDM1: rd_addr = mid - ADDR_W'(1);
      RD_LO:    rd_addr = lo[ADDR_W-1:0];
      RD_ZERO:  rd_addr = '0;
      RD_PIV:   rd_addr = piv;
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      mem[in_index] <= in_value;
    end
    rdata <= $signed(mem[rd_addr]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
    end else if (cfg_we) begin
      elem_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_START: begin
        key <= $signed(in_key);
        n   <= n_clamp;
        lo  <= '0;
        hi  <= $signed({1'b0, n_clamp}) - IDX_W'(1);
      end
      DP_MID:         mid <= mid_w;
      DP_CAP_VM:      vm  <= rdata;
      DP_PIV_MID:     piv <= mid;
      DP_PIV_MIDM1:   piv <= mid - ADDR_W'(1);
      DP_PIV_LO:      piv <= lo[ADDR_W-1:0];
      DP_HI_MIDM1:    hi  <= mid_s - IDX_W'(1);
      DP_LO_MIDP1:    lo  <= mid_s + IDX_W'(1);
      DP_BIS_FULL: begin
        lo <= '0;
        hi <= n_s - IDX_W'(1);
      end
      DP_BIS_LOW: begin
        lo <= '0;
        hi <= piv_s - IDX_W'(1);
      end
      DP_BIS_HIGH: begin
        lo <= piv_s + IDX_W'(1);
        hi <= n_s - IDX_W'(1);
      end
      DP_RES_HIT_PIV: begin
        res_found <= 1'b1;
        res_pos   <= POS_W'(piv);
      end
      DP_RES_HIT_MID: begin
        res_found <= 1'b1;
        res_pos   <= POS_W'(mid);
      end
      DP_RES_MISS: begin
        res_found <= 1'b0;
        res_pos   <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found <= res_found;
      out_pos   <= res_pos;
    end
  end

  assign out_data = {1'b0, out_pos, out_found};

  always_comb begin
    st.lo_gt_hi  = lo > hi;
    st.lo_eq_hi  = lo == hi;
    st.mid_lt_hi = mid_s < hi;
    st.mid_gt_lo = mid_s > lo;
    st.vm_gt_rd  = vm > rdata;
    st.vm_lt_rd  = vm < rdata;
    st.rd_ge_vm  = rdata >= vm;
    st.key_eq_rd = key == rdata;
    st.key_gt_rd = key > rdata;
    st.rd_le_key = rdata <= key;
    st.out_free  = !out_valid || out_ready;
  end

`ifndef SYNTH
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result not presented after load");

  a_mid_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_MID) |-> (lo <= hi && lo >= 0))
    else $error("probe taken on an empty range");

  a_start_bounds: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_START) |=> (lo == 0 && hi == n_s - IDX_W'(1)))
    else $error("search bounds not set from count");
`endif

endmodule

`default_nettype wire

// ===== src/rsas_controller.sv =====
`default_nettype none

module rsas_controller
  import rsas_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_action,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && in_action == ACT_SEARCH) begin
          state_next = S_P_ITER;
        end
      end
      S_P_ITER: begin
        if (st.lo_gt_hi) begin
          state_next = S_B_ITER;
        end else if (st.lo_eq_hi) begin
          state_next = S_C_PIV;
        end else begin
          state_next = S_P_M;
        end
      end
      S_P_M: begin
        if (st.mid_lt_hi) begin
          state_next = S_P_N;
        end else if (st.mid_gt_lo) begin
          state_next = S_P_P;
        end else begin
          state_next = S_P_L;
        end
      end
      S_P_N: begin
        if (st.vm_gt_rd) begin
          state_next = S_C_PIV;
        end else if (st.mid_gt_lo) begin
          state_next = S_P_P;
        end else begin
          state_next = S_P_L;
        end
      end
      S_P_P: begin
        if (st.vm_lt_rd) begin
          state_next = S_C_PIV;
        end else begin
          state_next = S_P_L;
        end
      end
      S_P_L:   state_next = S_P_ITER;
      S_C_PIV: state_next = S_C_PV;
      S_C_PV: begin
        if (st.key_eq_rd) begin
          state_next = S_RES;
        end else begin
          state_next = S_C_Z;
        end
      end
      S_C_Z:   state_next = S_B_ITER;
      S_B_ITER: begin
        if (st.lo_gt_hi) begin
          state_next = S_RES;
        end else begin
          state_next = S_B_CMP;
        end
      end
      S_B_CMP: begin
        if (st.key_eq_rd) begin
          state_next = S_RES;
        end else begin
          state_next = S_B_ITER;
        end
      end
      S_RES: begin
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = DP_NONE;
    cmd.rd       = RD_MIDW;
    cmd.out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op = (in_action == ACT_SEARCH) ? DP_START : DP_LOAD;
        end
      end
      S_P_ITER: begin
        if (st.lo_gt_hi) begin
          cmd.op = DP_BIS_FULL;
        end else if (st.lo_eq_hi) begin
          cmd.op = DP_PIV_LO;
        end else begin
          cmd.op = DP_MID;
          cmd.rd = RD_MIDW;
        end
      end
      S_P_M: begin
        cmd.op = DP_CAP_VM;
        if (st.mid_lt_hi) begin
          cmd.rd = RD_MIDP1;
        end else if (st.mid_gt_lo) begin
          cmd.rd = RD_MIDM1;
        end else begin
          cmd.rd = RD_LO;
        end
      end
      S_P_N: begin
        if (st.vm_gt_rd) begin
          cmd.op = DP_PIV_MID;
        end else if (st.mid_gt_lo) begin
          cmd.rd = RD_MIDM1;
        end else begin
          cmd.rd = RD_LO;
        end
      end
      S_P_P: begin
        if (st.vm_lt_rd) begin
          cmd.op = DP_PIV_MIDM1;
        end else begin
          cmd.rd = RD_LO;
        end
      end
      S_P_L: begin
        cmd.op = st.rd_ge_vm ? DP_HI_MIDM1 : DP_LO_MIDP1;
      end
      S_C_PIV: begin
        cmd.rd = RD_PIV;
      end
      S_C_PV: begin
        if (st.key_eq_rd) begin
          cmd.op = DP_RES_HIT_PIV;
        end else begin
          cmd.rd = RD_ZERO;
        end
      end
      S_C_Z: begin
        cmd.op = st.rd_le_key ? DP_BIS_LOW : DP_BIS_HIGH;
      end
      S_B_ITER: begin
        if (st.lo_gt_hi) begin
          cmd.op = DP_RES_MISS;
        end else begin
          cmd.op = DP_MID;
          cmd.rd = RD_MIDW;
        end
      end
      S_B_CMP: begin
        if (st.key_eq_rd) begin
          cmd.op = DP_RES_HIT_MID;
        end else if (st.key_gt_rd) begin
          cmd.op = DP_LO_MIDP1;
        end else begin
          cmd.op = DP_HI_MIDM1;
        end
      end
      S_RES: begin
        cmd.out_load = st.out_free;
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTH
  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_action == ACT_SEARCH) |=> (state == S_P_ITER))
    else $error("search transfer did not start the pivot scan");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && in_action == ACT_LOAD) |=> (state == S_IDLE))
    else $error("load transfer left the idle state");

  a_result_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES && st.out_free) |=> (state == S_IDLE))
    else $error("result stage did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== src/rotated_sorted_array_search.sv =====
// Search in a rotated ascending array of distinct signed 32-bit words.
// Input stream: s_axis_tuser selects the action (0 loads one element, 1 searches).
// A load transfer writes s_axis_tdata element_value at index and gives no result;
// loads are taken one per cycle while the block is idle.
// A search transfer gives one result transfer on the m_axis group with the
// found flag and the matching position (0 when not found).
// The user must write the element count through cfg_we/cfg_wdata only while no search
// is in flight; the block itself does not enforce this. A search takes the transfer,
// runs the pivot probes, checks the pivot against the key and chooses a half, then
// runs binary-search probes until a hit or an empty range, and registers the result.
// All reads go through the single read port of the element store.
// One search is in flight at a time; the next transfer is taken once the
// result sits in the output register, even if the receiver has not yet taken it.
// If the receiver stalls, the result holds and the next search waits at its end.
// Reset clears the element count and the controller; stored elements are
// undefined until loaded.
`default_nettype none

module rotated_sorted_array_search
  import rsas_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: index, element_value, search_key, zero pad.
  input  wire logic [IN_W-1:0]   s_axis_tdata,
  // Fields from bit 0: action.
  input  wire logic              s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // Fields from bit 0: found, position, zero pad.
  output logic [OUT_W-1:0]       m_axis_tdata
);

  cmd_t    cmd;
  status_t st;

  rsas_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .st        (st),
    .cmd       (cmd)
  );

  rsas_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire
